// ----- design/binary_to_decimal_ascii_macros.svh -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, masked during reset
`define B2DA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b2da assertion failed");

// next-cycle implication, masked during reset
`define B2DA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b2da assertion failed");

// next-cycle implication, also checked across reset
`define B2DA_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("b2da reset assertion failed");

`endif

// ----- design/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// b2da_pkg
// shared constants and types of the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int INPUT_WIDTH_DEF = 32;
    localparam int DIGIT_COUNT_DEF = 10;
    localparam int VALUE_W         = 32;
    localparam int ASCII_W         = 6;
    localparam int DIGIT_W         = 4;
    // input bits folded into the digit store per cycle
    localparam int STEP_BITS       = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [DIGIT_W-1:0] ADD_THRESH = 4'd5;
    localparam logic [DIGIT_W-1:0] ADD_VAL    = 4'd3;
    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_HOLD
    } t_front_state;

endpackage

// ----- design/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// unsigned binary to decimal ascii text, double dabble conversion
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_ready/i_value carries one number per transaction.
//   output channel o_valid/i_ready carries one character per transaction,
//   o_ascii_digit '0'..'9' most significant first, o_last on the final digit.
//   leading zeros are dropped, zero gives a single '0'.
// conversion: the front folds 4 input bits per cycle in FS_CONV, then
//   offers the bcd word to the queue from FS_HOLD; the back walks it
//   from the leading digit down.
// overlap: the front accepts a new number in the same cycle as it hands
//   the last one to the queue, and the back sends one character per
//   cycle while i_ready is high.
//   a two-entry queue between front and back lets one side stall alone.
// reset: synchronous active-low i_rst_n empties the queue, drops any
//   number in flight and clears o_valid.
// stall: with i_ready low the output character holds; the front keeps
//   converting until the queue fills, then holds its word and o_ready stays low.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int INPUT_WIDTH = b2da_pkg::INPUT_WIDTH_DEF,
    parameter int DIGIT_COUNT = b2da_pkg::DIGIT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [b2da_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [b2da_pkg::ASCII_W-1:0] o_ascii_digit,
    output logic                         o_last
);

    localparam int Q_W = DIGIT_COUNT * b2da_pkg::DIGIT_W + $clog2(DIGIT_COUNT);

    logic           w_wr_valid;
    logic           w_wr_ready;
    logic [Q_W-1:0] w_wr_data;
    logic           w_rd_valid;
    logic           w_rd_ready;
    logic [Q_W-1:0] w_rd_data;

    b2da_front #(
        .INPUT_WIDTH (INPUT_WIDTH),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_wr_valid (w_wr_valid),
        .i_wr_ready (w_wr_ready),
        .o_wr_data  (w_wr_data)
    );

    b2da_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_wr_valid),
        .o_wr_ready (w_wr_ready),
        .i_wr_data  (w_wr_data),
        .o_rd_valid (w_rd_valid),
        .i_rd_ready (w_rd_ready),
        .o_rd_data  (w_rd_data)
    );

    b2da_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_rd_valid),
        .o_q_ready     (w_rd_ready),
        .i_q_data      (w_rd_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ascii_digit (o_ascii_digit),
        .o_last        (o_last)
    );

endmodule

// ----- design/b2da_front.sv -----
// ----------------------------------------------------------------------------
// b2da_front
// accepts a value, runs shift-and-add-3 a few bits per cycle, finds the
// leading digit and hands the bcd word to the queue
// ----------------------------------------------------------------------------
module b2da_front #(
    parameter int INPUT_WIDTH = b2da_pkg::INPUT_WIDTH_DEF,
    parameter int DIGIT_COUNT = b2da_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [b2da_pkg::VALUE_W-1:0]                    i_value,
    output logic                                            o_wr_valid,
    input  logic                                            i_wr_ready,
    output logic [DIGIT_COUNT*b2da_pkg::DIGIT_W+$clog2(DIGIT_COUNT)-1:0] o_wr_data
);

    localparam int DW    = b2da_pkg::DIGIT_W;
    localparam int BCD_W = DIGIT_COUNT * DW;
    localparam int IDX_W = $clog2(DIGIT_COUNT);
    localparam int SB    = b2da_pkg::STEP_BITS;
    localparam int STEPS = (INPUT_WIDTH + SB - 1) / SB;
    localparam int PAD_W = STEPS * SB;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    b2da_pkg::t_front_state r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [PAD_W-1:0]       r_shift;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       w_bcd_next;
    logic [INPUT_WIDTH-1:0] w_val;
    logic [IDX_W-1:0]       w_first;
    logic                   w_accept;
    logic                   w_push;
    logic                   w_last_step;

    generate
        if (INPUT_WIDTH <= b2da_pkg::VALUE_W) begin : g_trunc
            assign w_val = i_value[INPUT_WIDTH-1:0];
        end else begin : g_ext
            assign w_val = {{(INPUT_WIDTH-b2da_pkg::VALUE_W){1'b0}}, i_value};
        end
    endgenerate

    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int j = 0; j < DIGIT_COUNT; j++) begin
            if (bcd[j*DW +: DW] >= b2da_pkg::ADD_THRESH) begin
                adj[j*DW +: DW] = bcd[j*DW +: DW] + b2da_pkg::ADD_VAL;
            end
        end
        // carry out of the top digit drops off
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    always_comb begin
        w_bcd_next = r_bcd;
        for (int s = 0; s < SB; s++) begin
            w_bcd_next = dabble_step(w_bcd_next, r_shift[PAD_W-1-s]);
        end
    end

    // highest nonzero digit, zero keeps one digit
    always_comb begin
        w_first = '0;
        for (int j = 1; j < DIGIT_COUNT; j++) begin
            if (r_bcd[j*DW +: DW] != '0) begin
                w_first = IDX_W'(j);
            end
        end
    end

    assign w_last_step = (r_cnt == CNT_W'(STEPS-1));
    assign w_accept    = i_valid && o_ready;
    assign w_push      = o_wr_valid && i_wr_ready;
    assign o_wr_data   = {w_first, r_bcd};

    always_comb begin
        n_state = r_state;
        case (r_state)
            b2da_pkg::FS_IDLE: begin
                if (w_accept) n_state = b2da_pkg::FS_CONV;
            end
            b2da_pkg::FS_CONV: begin
                if (w_last_step) n_state = b2da_pkg::FS_HOLD;
            end
            b2da_pkg::FS_HOLD: begin
                if (w_accept) n_state = b2da_pkg::FS_CONV;
                else if (w_push) n_state = b2da_pkg::FS_IDLE;
            end
            default: n_state = b2da_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_wr_valid = 1'b0;
        case (r_state)
            b2da_pkg::FS_IDLE: begin
                o_ready = 1'b1;
            end
            b2da_pkg::FS_HOLD: begin
                o_wr_valid = 1'b1;
                o_ready    = i_wr_ready;
            end
            default: begin
                o_ready    = 1'b0;
                o_wr_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2da_pkg::FS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == b2da_pkg::FS_CONV) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_shift <= PAD_W'(w_val);
            r_bcd   <= '0;
        end else if (r_state == b2da_pkg::FS_CONV) begin
            r_shift <= r_shift << SB;
            r_bcd   <= w_bcd_next;
        end
    end

endmodule

// ----- design/b2da_queue.sv -----
// ----------------------------------------------------------------------------
// b2da_queue
// small fifo of converted bcd words between front and back
// ----------------------------------------------------------------------------
module b2da_queue #(
    parameter int WIDTH = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int DEPTH = b2da_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- design/b2da_back.sv -----
// ----------------------------------------------------------------------------
// b2da_back
// walks a bcd word from its leading digit down and sends one ascii
// character per cycle while i_ready is high, through an output register
// ----------------------------------------------------------------------------
module b2da_back #(
    parameter int DIGIT_COUNT = b2da_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_q_valid,
    output logic                                            o_q_ready,
    input  logic [DIGIT_COUNT*b2da_pkg::DIGIT_W+$clog2(DIGIT_COUNT)-1:0] i_q_data,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [b2da_pkg::ASCII_W-1:0]                    o_ascii_digit,
    output logic                                            o_last
);

    localparam int DW    = b2da_pkg::DIGIT_W;
    localparam int BCD_W = DIGIT_COUNT * DW;
    localparam int IDX_W = $clog2(DIGIT_COUNT);

    logic [DIGIT_COUNT-1:0][DW-1:0] r_bcd;
    logic [IDX_W-1:0]               r_idx;
    logic                           r_active;
    logic                           r_valid;
    logic [b2da_pkg::ASCII_W-1:0]   r_digit;
    logic                           r_last;
    logic                           w_advance;
    logic                           w_final;
    logic                           w_pop;

    assign w_advance = r_active && (!r_valid || i_ready);
    assign w_final   = (r_idx == '0);
    assign w_pop     = i_q_valid && (!r_active || (w_advance && w_final));
    assign o_q_ready = w_pop;

    assign o_valid       = r_valid;
    assign o_ascii_digit = r_digit;
    assign o_last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (w_advance) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_pop) begin
                r_active <= 1'b1;
            end else if (w_advance && w_final) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_digit <= b2da_pkg::ASCII_ZERO + b2da_pkg::ASCII_W'(r_bcd[r_idx]);
            r_last  <= w_final;
        end
        if (w_pop) begin
            r_bcd <= i_q_data[BCD_W-1:0];
            r_idx <= i_q_data[BCD_W +: IDX_W];
        end else if (w_advance) begin
            r_idx <= r_idx - 1'b1;
        end
    end

endmodule

// ----- design/b2da_checker.sv -----
// ----------------------------------------------------------------------------
// b2da_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_macros.svh"

module b2da_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [b2da_pkg::VALUE_W-1:0] i_value,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [b2da_pkg::ASCII_W-1:0] o_ascii_digit,
    input logic                         o_last
);

    logic w_digit_ok;
    assign w_digit_ok = (o_ascii_digit >= b2da_pkg::ASCII_ZERO) &&
                        (o_ascii_digit <= b2da_pkg::ASCII_ZERO + 6'd9);

    // characters are always decimal digits
    `B2DA_ASSERT_IMP(a_digit_range, o_valid, w_digit_ok)
    `B2DA_ASSERT_NXT(a_valid_holds, o_valid && !i_ready, o_valid)
    `B2DA_ASSERT_NXT(a_data_holds, o_valid && !i_ready, $stable(o_ascii_digit) && $stable(o_last))
    // a waiting input transaction keeps its value
    `B2DA_ASSERT_NXT(a_input_holds, i_valid && !o_ready, i_valid && $stable(i_value))
    // no character is offered after a reset cycle
    `B2DA_ASSERT_RST(a_reset_clears, !i_rst_n, !o_valid)

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
